/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the CRC unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define MSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds through reset.
`define MSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

/* src/msc_pkg.sv */
// ----------------------------------------------------------------------------
// msc_pkg
// Types and constants shared by the multi-standard CRC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    typedef logic [1:0] crc_mode_t;

    // Mode codes; the unused code folds as CRC-32.
    localparam crc_mode_t MODE_ARC   = 2'd0;
    localparam crc_mode_t MODE_CCITT = 2'd1;
    localparam crc_mode_t MODE_CRC32 = 2'd2;

    localparam logic [15:0] POLY_ARC     = 16'hA001;
    localparam logic [15:0] POLY_CCITT   = 16'h1021;
    localparam logic [31:0] POLY_CRC32   = 32'h04C1_1DB7;
    localparam logic [15:0] INIT_ARC     = 16'h0000;
    localparam logic [15:0] INIT_CCITT   = 16'hFFFF;
    localparam logic [31:0] INIT_CRC32   = 32'hFFFF_FFFF;
    localparam logic [31:0] XOROUT_CRC32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] remainder;
        logic [31:0] crc_value;
    } fold_res_t;

endpackage

`default_nettype wire

/* src/multi_standard_crc_unit.sv */
// ----------------------------------------------------------------------------
// multi_standard_crc_unit
// Byte-serial CRC engine: reflected CRC-16 (byte-swapped), CRC-16 CCITT or
// CRC-32, one finished CRC word per input byte.
// ----------------------------------------------------------------------------
// Takes one byte word per clock when the output is not stalled; its CRC word
// passes the input register, then the result register. The rate is set by
// the combinational eight-bit fold that feeds the remainder register;
// back-pressure on the output stalls the input register and the fold together.
// Write the mode register only while no word is in flight. s_tuser set reloads
// the mode initial value before that byte is folded; s_tlast is echoed on
// m_tlast. Without a first-byte word after reset folding starts from zero.
`default_nettype none

module multi_standard_crc_unit (
    input  var logic                aclk,
    input  var logic                aresetn,
    input  var logic                cfg_wr_en,
    input  var msc_pkg::crc_mode_t  cfg_wr_data,   // [1:0] crc_mode
    input  var logic                s_tvalid,
    output logic                    s_tready,
    input  var logic [7:0]          s_tdata,       // [7:0] data_byte
    input  var logic                s_tuser,       // [0] first_byte
    input  var logic                s_tlast,       // last_byte
    output logic                    m_tvalid,
    input  var logic                m_tready,
    output logic [31:0]             m_tdata,       // [31:0] crc_value
    output logic                    m_tlast        // is_final
);
    import msc_pkg::*;

    crc_mode_t   mode_reg;
    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic [31:0] rem_reg;
    logic        out_valid_reg;
    logic [31:0] out_crc_reg;
    logic        out_last_reg;
    logic        advance;
    fold_res_t   fold_res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ARC;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= '{data_byte: s_tdata, first_byte: s_tuser, last_byte: s_tlast};
        end
    end

    msc_fold u_fold (
        .crc_mode  (mode_reg),
        .remainder (rem_reg),
        .word      (in_word_reg),
        .res       (fold_res)
    );

    // remainder and result register move together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= 32'h0000_0000;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                rem_reg <= fold_res.remainder;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_crc_reg  <= fold_res.crc_value;
            out_last_reg <= in_word_reg.last_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* src/msc_fold.sv */
// ----------------------------------------------------------------------------
// msc_fold
// Folds one byte into the running remainder for the selected CRC mode and
// forms the finished CRC of the message so far.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_fold (
    input  var msc_pkg::crc_mode_t crc_mode,
    input  var logic [31:0]        remainder,
    input  var msc_pkg::in_word_t  word,
    output msc_pkg::fold_res_t     res
);
    import msc_pkg::*;

    logic [15:0] arc_r;
    logic [15:0] ccitt_r;
    logic [31:0] crc32_r;

    // Reflected CRC-16, LSB first.
    always_comb begin
        arc_r = (word.first_byte ? INIT_ARC : remainder[15:0]) ^ {8'h00, word.data_byte};
        for (int i = 0; i < 8; i++) begin
            arc_r = arc_r[0] ? ((arc_r >> 1) ^ POLY_ARC) : (arc_r >> 1);
        end
    end

    always_comb begin
        ccitt_r = (word.first_byte ? INIT_CCITT : remainder[15:0]) ^ {word.data_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            ccitt_r = ccitt_r[15] ? ((ccitt_r << 1) ^ POLY_CCITT) : (ccitt_r << 1);
        end
    end

    always_comb begin
        crc32_r = (word.first_byte ? INIT_CRC32 : remainder) ^ {word.data_byte, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            crc32_r = crc32_r[31] ? ((crc32_r << 1) ^ POLY_CRC32) : (crc32_r << 1);
        end
    end

    always_comb begin
        unique case (crc_mode)
            MODE_ARC: begin
                res.remainder = {16'h0000, arc_r};
                // delivered byte-swapped
                res.crc_value = {16'h0000, arc_r[7:0], arc_r[15:8]};
            end
            MODE_CCITT: begin
                res.remainder = {16'h0000, ccitt_r};
                res.crc_value = {16'h0000, ccitt_r};
            end
            default: begin
                res.remainder = crc32_r;
                res.crc_value = crc32_r ^ XOROUT_CRC32;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/msc_checker.sv */
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks on the CRC unit's stream handshake and pipeline timing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module msc_checker (
    input var logic        aclk,
    input var logic        aresetn,
    input var logic        s_tvalid,
    input var logic        s_tready,
    input var logic        m_tvalid,
    input var logic        m_tready,
    input var logic [31:0] m_tdata,
    input var logic        m_tlast
);

    // reset empties the pipeline
    `MSC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // a stalled result word holds
    `MSC_ASSERT(a_stall_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // an open output never blocks the input side
    `MSC_ASSERT(a_ready_flow, aclk, aresetn, m_tready |-> s_tready)

    // a new result needs a word that was accepted and then held in the input register
    `MSC_ASSERT(a_result_origin, aclk, aresetn,
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

endmodule

bind multi_standard_crc_unit msc_checker u_msc_checker (.*);

`default_nettype wire
